FILE: hw/rtl/segment_disk_intersection_test_core_defines.svh
// ----------------------------------------------------------------------------
// segment_disk_intersection_test_core_defines.svh
// Assertion macros shared by the disk intersection checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISK_INTERSECTION_TEST_CORE_DEFINES_SVH
`define SEGMENT_DISK_INTERSECTION_TEST_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SDIT_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SDIT_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sdit_pkg.sv
// ----------------------------------------------------------------------------
// sdit_pkg
// Constants and codes for the segment / disk intersection test core.
// ----------------------------------------------------------------------------
package sdit_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int RADIUS_BITS    = 23;
    localparam int PLANE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;

    // item enters at stage 1, result register is stage 10
    localparam int PIPE_DEPTH     = 10;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Z     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISK_RADIUS  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_SELECT = 3'd4;

    localparam logic [PLANE_BITS-1:0] PLANE_XY = 2'd0;
    localparam logic [PLANE_BITS-1:0] PLANE_XZ = 2'd1;
    localparam logic [PLANE_BITS-1:0] PLANE_YZ = 2'd2;

    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_POINT   = 1'b1;

endpackage

FILE: hw/rtl/segment_disk_intersection_test_core.sv
// ----------------------------------------------------------------------------
// segment_disk_intersection_test_core
// Segment and point tests against an axis-aligned circular detector disk.
// ----------------------------------------------------------------------------
// A test is taken on every cycle with start high and busy low; busy is high
// only for the first cycle out of reset. Each test gives one result, shown on
// hit and crossed_plane for one cycle with done high, from the last pipeline
// register. The ten-stage pipeline takes one test per cycle while busy is
// low, with no stall; the done strobe cannot be held off. Depth is set by the
// two multiplier rows: the crossing products and the split squares of the
// in-plane distance and limit. Configuration must be written only while no
// test is in flight (not enforced by the block); cfg_ready is always high.
module segment_disk_intersection_test_core #(
    parameter int COORD_BITS = sdit_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [((COORD_BITS > sdit_pkg::RADIUS_BITS) ?
                   COORD_BITS : sdit_pkg::RADIUS_BITS)-1:0] cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        start_z,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic signed [COORD_BITS-1:0]        end_z,
    output logic                                done,
    output logic                                hit,
    output logic                                crossed_plane
);

    import sdit_pkg::*;

    localparam int DW = COORD_BITS + 1;          // coordinate difference
    localparam int PW = 2 * DW + 1;              // diff x (den or num)
    localparam int EW = PW + 1;                  // sum of two products
    localparam int LW = RADIUS_BITS + DW;        // radius x den
    localparam int CW = (EW > LW) ? EW : LW;
    localparam int HL = (LW + 1) / 2;            // low half of a square operand
    localparam int HH = LW - HL;
    localparam int SW = 2 * LW;                  // square width

    // configuration
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [RADIUS_BITS-1:0]       disk_radius_reg;
    logic [PLANE_BITS-1:0]        plane_select_reg;

    // control
    logic                         busy_reg, busy_next;
    logic [PIPE_DEPTH-1:0]        valid_reg, valid_next;

    // stage 1: axis selection and differences
    logic signed [COORD_BITS-1:0] sel_sn, sel_su, sel_sv, sel_en, sel_eu, sel_ev;
    logic signed [COORD_BITS-1:0] sel_cn, sel_cu, sel_cv;
    logic                         req1_reg, req1_next, ok1_reg, ok1_next;
    logic signed [DW-1:0]         du1_reg, dv1_reg, mu1_reg, mv1_reg, num1_reg, den1_reg;
    logic signed [DW-1:0]         du1_next, dv1_next, mu1_next, mv1_next, num1_next, den1_next;

    // stage 2: crossing decision, normalised num / den
    logic                         den_pos, den_neg, seg_ok, point_ok;
    logic                         cross2_reg, cross2_next;
    logic signed [DW-1:0]         du2_reg, dv2_reg, mu2_reg, mv2_reg;
    logic [DW-1:0]                num2_reg, num2_next, den2_reg, den2_next;

    // stage 3: products
    logic                         cross3_reg;
    logic signed [PW-1:0]         pu0_reg, pu1_reg, pv0_reg, pv1_reg;
    logic signed [PW-1:0]         pu0_next, pu1_next, pv0_next, pv1_next;
    logic [LW-1:0]                lim3_reg, lim3_next;

    // stage 4: distance numerators
    logic                         cross4_reg;
    logic signed [EW-1:0]         eu4_reg, ev4_reg, eu4_next, ev4_next;
    logic [LW-1:0]                lim4_reg;

    // stage 5: magnitudes
    logic                         cross5_reg;
    logic [EW-1:0]                au5_reg, av5_reg, au5_next, av5_next;
    logic [LW-1:0]                lim5_reg;

    // stage 6: range check
    logic [CW-1:0]                au_ext, av_ext, lim_ext;
    logic                         cross6_reg, rng6_reg, rng6_next;
    logic [LW-1:0]                au6_reg, av6_reg, lim6_reg, au6_next, av6_next;

    // stage 7: partial products of the squares
    logic                         cross7_reg, rng7_reg;
    logic [2*HH-1:0]              uhh7_reg, vhh7_reg, lhh7_reg;
    logic [HH+HL-1:0]             uhl7_reg, vhl7_reg, lhl7_reg;
    logic [2*HL-1:0]              ull7_reg, vll7_reg, lll7_reg;

    // stage 8: squares
    logic                         cross8_reg, rng8_reg;
    logic [SW-1:0]                squ8_reg, sqv8_reg, sql8_reg;
    logic [SW-1:0]                squ8_next, sqv8_next, sql8_next;

    // stage 9: sum of squares
    logic                         cross9_reg, rng9_reg;
    logic [SW:0]                  sum9_reg, sum9_next;
    logic [SW-1:0]                sql9_reg;

    // stage 10: result
    logic                         hit_reg, hit_next, crossed_reg;

    assign cfg_ready     = 1'b1;
    assign busy          = busy_reg;
    assign done          = valid_reg[PIPE_DEPTH-1];
    assign hit           = hit_reg;
    assign crossed_plane = crossed_reg;

    assign busy_next  = 1'b0;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start & ~busy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b1;
            valid_reg        <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            disk_radius_reg  <= '0;
            plane_select_reg <= PLANE_XY;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CENTER_X:     center_x_reg     <= cfg_data[COORD_BITS-1:0];
                    CFG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_BITS-1:0];
                    CFG_CENTER_Z:     center_z_reg     <= cfg_data[COORD_BITS-1:0];
                    CFG_DISK_RADIUS:  disk_radius_reg  <= cfg_data[RADIUS_BITS-1:0];
                    CFG_PLANE_SELECT: plane_select_reg <= cfg_data[PLANE_BITS-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // stage 1
    always_comb
    begin
        case (plane_select_reg)
            PLANE_XY:
            begin
                sel_sn = start_z; sel_su = start_x; sel_sv = start_y;
                sel_en = end_z;   sel_eu = end_x;   sel_ev = end_y;
                sel_cn = center_z_reg; sel_cu = center_x_reg; sel_cv = center_y_reg;
            end
            PLANE_XZ:
            begin
                sel_sn = start_y; sel_su = start_x; sel_sv = start_z;
                sel_en = end_y;   sel_eu = end_x;   sel_ev = end_z;
                sel_cn = center_y_reg; sel_cu = center_x_reg; sel_cv = center_z_reg;
            end
            default:
            begin
                sel_sn = start_x; sel_su = start_y; sel_sv = start_z;
                sel_en = end_x;   sel_eu = end_y;   sel_ev = end_z;
                sel_cn = center_x_reg; sel_cu = center_y_reg; sel_cv = center_z_reg;
            end
        endcase
        ok1_next  = plane_select_reg inside {PLANE_XY, PLANE_XZ, PLANE_YZ};
        req1_next = req_type;
        du1_next  = DW'(sel_su) - DW'(sel_cu);
        dv1_next  = DW'(sel_sv) - DW'(sel_cv);
        mu1_next  = DW'(sel_eu) - DW'(sel_su);
        mv1_next  = DW'(sel_ev) - DW'(sel_sv);
        num1_next = DW'(sel_cn) - DW'(sel_sn);
        den1_next = DW'(sel_en) - DW'(sel_sn);
    end

    // stage 2: 0 <= t <= 1 by sign tests; a point test becomes den 1, num 0
    always_comb
    begin
        den_neg  = den1_reg[DW-1];
        den_pos  = !den1_reg[DW-1] && (den1_reg != '0);
        point_ok = (num1_reg == '0);
        if (den_pos)
            seg_ok = !num1_reg[DW-1] && (num1_reg <= den1_reg);
        else if (den_neg)
            seg_ok = (num1_reg[DW-1] || point_ok) && (num1_reg >= den1_reg);
        else
            seg_ok = 1'b0;
        if (req1_reg == REQ_POINT)
        begin
            cross2_next = ok1_reg && point_ok;
            num2_next   = '0;
            den2_next   = DW'(1);
        end
        else
        begin
            cross2_next = ok1_reg && seg_ok;
            num2_next   = den_neg ? DW'(-num1_reg) : DW'(num1_reg);
            den2_next   = den_neg ? DW'(-den1_reg) : DW'(den1_reg);
        end
    end

    // stage 3
    always_comb
    begin
        pu0_next  = du2_reg * $signed({1'b0, den2_reg});
        pu1_next  = mu2_reg * $signed({1'b0, num2_reg});
        pv0_next  = dv2_reg * $signed({1'b0, den2_reg});
        pv1_next  = mv2_reg * $signed({1'b0, num2_reg});
        lim3_next = LW'(disk_radius_reg) * LW'(den2_reg);
    end

    // stages 4 to 6
    always_comb
    begin
        eu4_next  = EW'(pu0_reg) + EW'(pu1_reg);
        ev4_next  = EW'(pv0_reg) + EW'(pv1_reg);
        au5_next  = eu4_reg[EW-1] ? EW'(-eu4_reg) : EW'(eu4_reg);
        av5_next  = ev4_reg[EW-1] ? EW'(-ev4_reg) : EW'(ev4_reg);
        au_ext    = CW'(au5_reg);
        av_ext    = CW'(av5_reg);
        lim_ext   = CW'(lim5_reg);
        rng6_next = (au_ext <= lim_ext) && (av_ext <= lim_ext);
        au6_next  = au_ext[LW-1:0];
        av6_next  = av_ext[LW-1:0];
    end

    // stages 8 to 10: a^2 = {ah^2, al^2} + 2*ah*al << HL
    always_comb
    begin
        squ8_next = {uhh7_reg, ull7_reg} + (SW'(uhl7_reg) << (HL + 1));
        sqv8_next = {vhh7_reg, vll7_reg} + (SW'(vhl7_reg) << (HL + 1));
        sql8_next = {lhh7_reg, lll7_reg} + (SW'(lhl7_reg) << (HL + 1));
        sum9_next = (SW + 1)'(squ8_reg) + (SW + 1)'(sqv8_reg);
        hit_next  = cross9_reg && rng9_reg && (sum9_reg <= (SW + 1)'(sql9_reg));
    end

    always_ff @(posedge clk)
    begin
        req1_reg   <= req1_next;
        ok1_reg    <= ok1_next;
        du1_reg    <= du1_next;
        dv1_reg    <= dv1_next;
        mu1_reg    <= mu1_next;
        mv1_reg    <= mv1_next;
        num1_reg   <= num1_next;
        den1_reg   <= den1_next;

        cross2_reg <= cross2_next;
        du2_reg    <= du1_reg;
        dv2_reg    <= dv1_reg;
        mu2_reg    <= mu1_reg;
        mv2_reg    <= mv1_reg;
        num2_reg   <= num2_next;
        den2_reg   <= den2_next;

        cross3_reg <= cross2_reg;
        pu0_reg    <= pu0_next;
        pu1_reg    <= pu1_next;
        pv0_reg    <= pv0_next;
        pv1_reg    <= pv1_next;
        lim3_reg   <= lim3_next;

        cross4_reg <= cross3_reg;
        eu4_reg    <= eu4_next;
        ev4_reg    <= ev4_next;
        lim4_reg   <= lim3_reg;

        cross5_reg <= cross4_reg;
        au5_reg    <= au5_next;
        av5_reg    <= av5_next;
        lim5_reg   <= lim4_reg;

        cross6_reg <= cross5_reg;
        rng6_reg   <= rng6_next;
        au6_reg    <= au6_next;
        av6_reg    <= av6_next;
        lim6_reg   <= lim5_reg;

        cross7_reg <= cross6_reg;
        rng7_reg   <= rng6_reg;
        uhh7_reg   <= au6_reg[LW-1:HL] * au6_reg[LW-1:HL];
        uhl7_reg   <= au6_reg[LW-1:HL] * au6_reg[HL-1:0];
        ull7_reg   <= au6_reg[HL-1:0] * au6_reg[HL-1:0];
        vhh7_reg   <= av6_reg[LW-1:HL] * av6_reg[LW-1:HL];
        vhl7_reg   <= av6_reg[LW-1:HL] * av6_reg[HL-1:0];
        vll7_reg   <= av6_reg[HL-1:0] * av6_reg[HL-1:0];
        lhh7_reg   <= lim6_reg[LW-1:HL] * lim6_reg[LW-1:HL];
        lhl7_reg   <= lim6_reg[LW-1:HL] * lim6_reg[HL-1:0];
        lll7_reg   <= lim6_reg[HL-1:0] * lim6_reg[HL-1:0];

        cross8_reg <= cross7_reg;
        rng8_reg   <= rng7_reg;
        squ8_reg   <= squ8_next;
        sqv8_reg   <= sqv8_next;
        sql8_reg   <= sql8_next;

        cross9_reg <= cross8_reg;
        rng9_reg   <= rng8_reg;
        sum9_reg   <= sum9_next;
        sql9_reg   <= sql8_reg;

        hit_reg     <= hit_next;
        crossed_reg <= cross9_reg;
    end

endmodule

FILE: hw/rtl/sdit_checker.sv
// ----------------------------------------------------------------------------
// sdit_checker
// Port-level checks on the disk intersection core, bound into every core instance.
// ----------------------------------------------------------------------------
`include "segment_disk_intersection_test_core_defines.svh"

module sdit_checker #(
    parameter int LATENCY = sdit_pkg::PIPE_DEPTH
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic crossed_plane
);

    import sdit_pkg::*;

    `SDIT_ASSERT_IMP(a_transfer_gives_result, clk, rst_n, start && !busy, ##LATENCY done, "transfer without result")
    `SDIT_ASSERT_IMP(a_result_has_transfer, clk, rst_n, done, $past(start && !busy, LATENCY), "result without transfer")
    `SDIT_ASSERT_IMP(a_hit_on_plane, clk, rst_n, done && hit, crossed_plane, "hit off the disk plane")
    `SDIT_ASSERT_NXT(a_busy_stays_low, clk, rst_n, !busy, !busy, "busy raised after reset")

endmodule

bind segment_disk_intersection_test_core sdit_checker u_sdit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .crossed_plane (crossed_plane)
);
